>>> sv/imcd_pkg.sv
`default_nettype none

package imcd_pkg;

  localparam logic [7:0] ICE_BYTE   = 8'h58;
  localparam logic [7:0] WATER_BYTE = 8'h2E;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic ACT_PUSH  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef struct packed {
    logic wr_mid;
    logic emit;
    logic has_l;
    logic has_r;
    logic has_u;
    logic has_d;
    logic last;
  } ctl_t;

  function automatic logic [7:0] melt(input logic [7:0] centre, input ctl_t ctl,
                                      input logic [7:0] l, input logic [7:0] r,
                                      input logic [7:0] u, input logic [7:0] d);
    logic wet;
    wet = (ctl.has_l && l == WATER_BYTE) || (ctl.has_r && r == WATER_BYTE) ||
          (ctl.has_u && u == WATER_BYTE) || (ctl.has_d && d == WATER_BYTE);
    if (centre == ICE_BYTE && wet) begin
      return WATER_BYTE;
    end
    return centre;
  endfunction

endpackage

`default_nettype wire

>>> sv/imcd_front.sv
`default_nettype none

module imcd_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  parameter int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic            cfg_index_i,
  input  wire logic [11:0]     cfg_data_i,
  input  wire logic            s_valid_i,
  input  wire logic            s_action_i,
  input  wire logic [7:0]      s_pixel_i,
  output logic                 s_ready_o,
  input  wire logic            q_full_i,
  output logic                 q_push_o,
  output imcd_pkg::ctl_t       q_ctl_o,
  output logic [AW-1:0]        q_col_o,
  output logic [7:0]           q_pixel_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [11:0]   width_q, width_d;
  logic [11:0]   height_q, height_d;
  logic [AW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;

  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic          col_last;
  logic          flush_phase;
  logic          is_push;
  logic          accept;
  logic          keep;

  always_comb begin
    if (width_q == 12'd0) begin
      eff_w = WW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    if (height_q == 12'd0) begin
      eff_h = HW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
  end

  assign col_last    = (32'(col_q) + 32'd1) >= 32'(eff_w);
  assign flush_phase = 32'(row_q) >= 32'(eff_h);
  assign is_push     = (s_action_i == imcd_pkg::ACT_PUSH);
  assign s_ready_o   = !q_full_i;
  assign accept      = s_valid_i && !q_full_i;
  assign keep        = is_push ? !flush_phase : flush_phase;
  assign q_push_o    = accept && keep;
  assign q_col_o     = col_q;
  assign q_pixel_o   = s_pixel_i;

  always_comb begin
    q_ctl_o.wr_mid = is_push;
    q_ctl_o.emit   = is_push ? (row_q != '0) : 1'b1;
    q_ctl_o.has_l  = (col_q != '0);
    q_ctl_o.has_r  = !col_last;
    q_ctl_o.has_u  = is_push ? (32'(row_q) >= 32'd2) : (32'(eff_h) >= 32'd2);
    q_ctl_o.has_d  = is_push;
    q_ctl_o.last   = !is_push && col_last;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    col_d    = col_q;
    row_d    = row_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        imcd_pkg::REG_FRAME_WIDTH:  width_d  = cfg_data_i;
        imcd_pkg::REG_FRAME_HEIGHT: height_d = cfg_data_i;
        default: ;
      endcase
      col_d = '0;
      row_d = '0;
    end else if (q_push_o) begin
      if (col_last) begin
        col_d = '0;
        row_d = is_push ? row_q + HW'(1) : '0;
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 12'd2048;
      height_q <= 12'd2048;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/imcd_queue.sv
`default_nettype none

module imcd_queue #(
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output logic [DW-1:0]      data_o
);

  localparam int QAW = imcd_pkg::QUEUE_AW;

  logic [DW-1:0]  mem_q [imcd_pkg::QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           do_pop;

  assign full_o  = (32'(cnt_q) == imcd_pkg::QUEUE_DEPTH);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QAW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + QAW'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + (QAW + 1)'(1);
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - (QAW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/imcd_back.sv
`default_nettype none

module imcd_back #(
  parameter int MAX_WIDTH = 2048,
  parameter int AW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_valid_i,
  input  wire imcd_pkg::ctl_t  q_ctl_i,
  input  wire logic [AW-1:0]   q_col_i,
  input  wire logic [7:0]      q_pixel_i,
  output logic                 q_pop_o,
  output logic                 m_valid_o,
  input  wire logic            m_ready_i,
  output logic [7:0]           m_pixel_o,
  output logic                 m_last_o
);

  logic [7:0] mid_mem [MAX_WIDTH];
  logic [7:0] up_mem  [MAX_WIDTH];

  logic           b_valid_q, b_valid_d;
  imcd_pkg::ctl_t b_ctl_q;
  logic [AW-1:0]  b_col_q;
  logic [7:0]     b_down_q;
  logic [7:0]     mid_c_q;
  logic [7:0]     mid_r_q;
  logic [7:0]     up_q;
  logic           fwd_q;
  logic [7:0]     fwd_data_q;
  logic [7:0]     left_q;

  logic           b_adv;
  logic           a_go;
  logic [AW-1:0]  right_idx;
  logic [7:0]     up_val;

  assign b_adv     = b_valid_q && (!b_ctl_q.emit || m_ready_i);
  assign a_go      = q_valid_i && (!b_valid_q || b_adv);
  assign q_pop_o   = a_go;
  assign right_idx = q_ctl_i.has_r ? q_col_i + AW'(1) : q_col_i;
  assign b_valid_d = a_go ? 1'b1 : (b_adv ? 1'b0 : b_valid_q);

  // The item ahead writes the upper line in the cycle this one reads it.
  assign up_val    = fwd_q ? fwd_data_q : up_q;

  assign m_valid_o = b_valid_q && b_ctl_q.emit;
  assign m_last_o  = b_ctl_q.last;
  assign m_pixel_o = imcd_pkg::melt(mid_c_q, b_ctl_q, left_q, mid_r_q, up_val, b_down_q);

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      mid_c_q <= mid_mem[q_col_i];
      mid_r_q <= mid_mem[right_idx];
      if (q_ctl_i.wr_mid) begin
        mid_mem[q_col_i] <= q_pixel_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      up_q <= up_mem[q_col_i];
    end
    if (b_adv) begin
      up_mem[b_col_q] <= mid_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_go) begin
      b_ctl_q    <= q_ctl_i;
      b_col_q    <= q_col_i;
      b_down_q   <= q_pixel_i;
      fwd_q      <= b_adv && (b_col_q == q_col_i);
      fwd_data_q <= mid_c_q;
    end
    if (b_adv) begin
      left_q <= mid_c_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= b_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> sv/ice_melt_cross_dilation.sv
// Throughput is one item per cycle while the output is not stalled; the back end reads its
// line memories into registers. When neither side stalls, the item that releases the result
// for the pixel one row up passes through the queue into the back-end stage register, where
// the result is shown; a four-entry queue lets the input run on ahead.
// Reset is asynchronous and active low: it clears the counters, the queue and the output
// stage, and sets both frame registers to 2048. The line memories keep their contents.
`default_nettype none

module ice_melt_cross_dilation #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_index_i,
  input  wire logic [11:0] cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // pixel_in
  input  wire logic        s_axis_tuser,   // action
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // pixel_out
  output logic             m_axis_tlast
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int QW = $bits(imcd_pkg::ctl_t) + AW + 8;

  logic           f_push;
  imcd_pkg::ctl_t f_ctl;
  logic [AW-1:0]  f_col;
  logic [7:0]     f_pixel;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic [QW-1:0]  q_din;
  logic [QW-1:0]  q_dout;
  imcd_pkg::ctl_t h_ctl;
  logic [AW-1:0]  h_col;
  logic [7:0]     h_pixel;

  assign q_din = {f_ctl, f_col, f_pixel};
  assign {h_ctl, h_col, h_pixel} = q_dout;

  imcd_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_valid_i   (s_axis_tvalid),
    .s_action_i  (s_axis_tuser),
    .s_pixel_i   (s_axis_tdata),
    .s_ready_o   (s_axis_tready),
    .q_full_i    (q_full),
    .q_push_o    (f_push),
    .q_ctl_o     (f_ctl),
    .q_col_o     (f_col),
    .q_pixel_o   (f_pixel)
  );

  imcd_queue #(
    .DW (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_dout)
  );

  imcd_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ctl_i   (h_ctl),
    .q_col_i   (h_col),
    .q_pixel_i (h_pixel),
    .q_pop_o   (q_pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_pixel_o (m_axis_tdata),
    .m_last_o  (m_axis_tlast)
  );

endmodule

`default_nettype wire

>>> sv/imcd_checker.sv
`default_nettype none

module imcd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // Leaving reset, nothing is pending at the output.
  a_reset_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result pending after reset");

  // Leaving reset, the input side is open.
  a_reset_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> s_axis_tready)
    else $error("input not ready after reset");

  // The first row of the next frame emits nothing, so a frame end leaves a gap.
  a_frame_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result directly after frame end");

endmodule

bind ice_melt_cross_dilation imcd_checker u_imcd_checker (.*);

`default_nettype wire
